// File: rtl/iov_pkg.sv
// ----------------------------------------------------------------------------
// iov_pkg
// Shared types and codes for the IPv4 option area validator.
// ----------------------------------------------------------------------------
package iov_pkg;

  // option type codes
  localparam logic [7:0] OPT_EOP  = 8'd0;
  localparam logic [7:0] OPT_NOP  = 8'd1;
  localparam logic [7:0] OPT_RR   = 8'd7;
  localparam logic [7:0] OPT_LSRR = 8'd131;
  localparam logic [7:0] OPT_SSRR = 8'd137;

  // length and pointer limits
  localparam logic [7:0] MIN_ROUTE_LEN = 8'd3;
  localparam logic [7:0] MIN_OPT_LEN   = 8'd2;
  localparam logic [7:0] SR_TX_PTR     = 8'd4;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_LEN  = 3'd1,
    PH_PTR  = 3'd2,
    PH_BODY = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_LEN   = 2'd1,
    FLT_PTR   = 2'd2,
    FLT_SRPTR = 2'd3
  } fault_t;

  // one input beat
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       is_last;
    logic       received;
  } beat_t;

  // one verdict
  typedef struct packed {
    logic   valid_res;
    fault_t fault;
  } verdict_t;

endpackage

// File: rtl/iov_in_stage.sv
// ----------------------------------------------------------------------------
// iov_in_stage
// Input register: holds one beat until the parser takes it.
// ----------------------------------------------------------------------------
module iov_in_stage
  import iov_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] opt_byte,
  input  logic       is_last,
  input  logic       received,
  input  logic       take,
  output logic       beat_valid,
  output beat_t      beat
);

  logic load;

  // room when empty or when the held beat leaves this cycle
  assign in_stall = beat_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (load) begin
      beat_valid <= 1'b1;
    end else if (take) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat.opt_byte <= opt_byte;
      beat.is_last  <= is_last;
      beat.received <= received;
    end
  end

endmodule

// File: rtl/iov_parser.sv
// ----------------------------------------------------------------------------
// iov_parser
// Option parse state and the per-byte update; forms the verdict on the
// last beat of an area.
// ----------------------------------------------------------------------------
module iov_parser
  import iov_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     beat_valid,
  input  beat_t    beat,
  input  logic     out_free,
  output logic     take,
  output logic     emit,
  output verdict_t res
);

  phase_t     phase, phase_next;
  logic [7:0] option_type, option_type_next;
  logic [7:0] option_length, option_length_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  fault_t     first_fault, first_fault_next;

  logic       route;
  logic [8:0] len_p1;
  logic [7:0] len_m3;
  logic       body_done;

  // a last beat waits for room in the output register
  assign take = beat_valid && (!beat.is_last || out_free);
  assign emit = take && beat.is_last;

  assign route  = (option_type == OPT_RR) || (option_type == OPT_LSRR) ||
                  (option_type == OPT_SSRR);
  assign len_p1 = {1'b0, option_length} + 9'd1;
  assign len_m3 = beat.opt_byte - MIN_ROUTE_LEN;
  assign body_done = ((bytes_seen + 8'd1) >= option_length);

  // next state
  always_comb begin
    phase_next         = phase;
    option_type_next   = option_type;
    option_length_next = option_length;
    bytes_seen_next    = bytes_seen;
    first_fault_next   = first_fault;
    unique case (phase)
      PH_TYPE: begin
        if (beat.opt_byte == OPT_EOP) begin
          phase_next = PH_DONE;
        end else if (beat.opt_byte != OPT_NOP) begin
          option_type_next = beat.opt_byte;
          bytes_seen_next  = 8'd1;
          phase_next       = PH_LEN;
        end
      end
      PH_LEN: begin
        option_length_next = beat.opt_byte;
        bytes_seen_next    = 8'd2;
        if (route) begin
          if (beat.opt_byte < MIN_ROUTE_LEN || len_m3[1:0] != 2'd0) begin
            first_fault_next = FLT_LEN;
            phase_next       = PH_DONE;
          end else begin
            phase_next = PH_PTR;
          end
        end else if (beat.opt_byte < MIN_OPT_LEN) begin
          first_fault_next = FLT_LEN;
          phase_next       = PH_DONE;
        end else if (beat.opt_byte == MIN_OPT_LEN) begin
          phase_next = PH_TYPE;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_PTR: begin
        bytes_seen_next = 8'd3;
        if ({1'b0, beat.opt_byte} > len_p1 || beat.opt_byte[1:0] != 2'd0) begin
          first_fault_next = FLT_PTR;
        end else if (option_type != OPT_RR &&
                     ((beat.received && {1'b0, beat.opt_byte} != len_p1) ||
                      (!beat.received && beat.opt_byte != SR_TX_PTR))) begin
          first_fault_next = FLT_SRPTR;
        end
        if (option_length <= 8'd3) begin
          phase_next = (first_fault_next != FLT_NONE) ? PH_DONE : PH_TYPE;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        bytes_seen_next = bytes_seen + 8'd1;
        if (body_done) begin
          phase_next = (first_fault != FLT_NONE) ? PH_DONE : PH_TYPE;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_TYPE;
      end
    endcase
  end

  // verdict: an option still open at area end is a length fault
  always_comb begin
    unique case (phase_next)
      PH_LEN, PH_PTR, PH_BODY: res.fault = FLT_LEN;
      default:                 res.fault = first_fault_next;
    endcase
    res.valid_res = (res.fault == FLT_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      phase         <= PH_TYPE;
      option_type   <= 8'd0;
      option_length <= 8'd0;
      bytes_seen    <= 8'd0;
      first_fault   <= FLT_NONE;
    end else if (take) begin
      phase         <= phase_next;
      option_type   <= option_type_next;
      option_length <= option_length_next;
      bytes_seen    <= bytes_seen_next;
      first_fault   <= first_fault_next;
    end
  end

endmodule

// File: rtl/ipv4_option_validator.sv
// ----------------------------------------------------------------------------
// ipv4_option_validator
// Checks an IPv4 option area streamed one byte per beat; one verdict per area.
// ----------------------------------------------------------------------------
// Feed the option area one byte per beat with is_last on its final byte. A
// verdict beat (valid_res, fault) comes out only for that final byte; other
// bytes give none. The block takes one beat every cycle, sustained, as long as
// the output side is not stalled. The verdict for an area is formed while its
// last byte sits in the input register and the parse logic works on it; it
// then lands in the output register. The rate is set by the parse state
// update, which handles exactly one byte per cycle. A finished verdict may
// sit in the output register while the next area's bytes keep flowing; only
// a second last byte waits for that register to drain. After a verdict the
// parser is back in its start state, so the next beat opens a new area.
// ----------------------------------------------------------------------------
module ipv4_option_validator
  import iov_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] opt_byte,
  input  logic       is_last,
  input  logic       received,
  // verdict channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       valid_res,
  output logic [1:0] fault
);

  logic     beat_valid;
  beat_t    beat;
  logic     take;
  logic     emit;
  logic     out_free;
  verdict_t res;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  iov_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opt_byte   (opt_byte),
    .is_last    (is_last),
    .received   (received),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  iov_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .out_free   (out_free),
    .take       (take),
    .emit       (emit),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      valid_res <= res.valid_res;
      fault     <= res.fault;
    end
  end

endmodule
